@@ rtl/svalloc_pkg.sv @@
// Shared types and constants of the sound voice allocator.
// Voice table entry layout, fill step result, item kinds and stream bit positions.
// No dependencies.
`default_nettype none

package svalloc_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        KIND_PLAY = 2'd0,
        KIND_FILL = 2'd1,
        KIND_STOP = 2'd2
    } kind_t;

    // Gain value meaning unity; larger register values clamp to it
    localparam logic [7:0] GAIN_UNITY = 8'd128;

    // Stream widths (whole bytes)
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 72;

    // Input beat layout
    localparam int S_BASE_LO  = 0;
    localparam int S_LEN_LO   = 32;
    localparam int S_LOOPS_LO = 56;
    localparam int S_NOW_LO   = 65;
    localparam int S_FILL_LO  = 97;
    localparam int S_CHAN_LO  = 113;

    // Output beat layout
    localparam int M_CHAN_LO   = 0;
    localparam int M_ADDR_LO   = 4;
    localparam int M_BYTES_LO  = 36;
    localparam int M_GAIN_LO   = 52;
    localparam int M_ACTIVE_LO = 60;
    localparam int M_PAUSED_LO = 65;

    // One voice table entry
    typedef struct packed {
        logic [31:0]        position;
        logic [23:0]        remaining;
        logic [31:0]        start;
        logic [23:0]        length;
        logic [31:0]        started_at;
        logic signed [8:0]  loops;
    } voice_entry_t;

    // Outcome of advancing one voice by one buffer
    typedef struct packed {
        logic [15:0]  amt;
        logic         stop;
        voice_entry_t entry;
    } adv_t;

    // One buffered copy command
    typedef struct packed {
        logic [3:0]  chan;
        logic [31:0] address;
        logic [15:0] bytes;
    } copy_cmd_t;

endpackage

`default_nettype wire

@@ rtl/sound_voice_allocator_top.sv @@
// Sound voice allocator: voice table in RAM, oldest-first stealing, buffer fills.
// A stop or unused kind gives one status beat; a play takes the lowest idle channel or
// steals the one with the oldest start time (one RAM read per channel). A fill gives one
// copy beat per active channel, one beat per cycle while m_tready holds (a status beat with no
// active channel). A new item is taken the cycle after the previous item's last result loads.
// Reset clears the active flags, the playing count and sets the gain to 128; RAM is not cleared.
`default_nettype none

module sound_voice_allocator_top #(
    parameter int VOICES = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input beats
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // sound_base, sound_length, loop_count, now_ms, fill_bytes, channel, zero pad
    input  wire logic [svalloc_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic [1:0]                        s_tuser,
    // result beats
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_channel, copy_address, copy_bytes, copy_gain, active_voices,
    // output_paused, zero pad
    output logic [svalloc_pkg::M_TDATA_W-1:0]      m_tdata,
    // copy_valid
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    // effects_gain writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [7:0]                        cfg_data
);

    import svalloc_pkg::*;

    localparam int CW   = $clog2(VOICES);
    localparam int CNTW = $clog2(VOICES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAY_WR,
        ST_SCAN,
        ST_FILL,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // control registers
    state_t              state_reg,  state_next;
    logic [7:0]          gain_reg,   gain_next;
    logic [VOICES-1:0]   active_reg, active_next;
    logic [CNTW-1:0]     count_reg,  count_next;
    logic                s1_v_reg,   s1_v_next;
    logic                rd_ok_reg,  rd_ok_next;
    logic                m_valid_reg, m_valid_next;

    // payload registers
    logic [31:0]         base_reg,   base_next;
    logic [23:0]         len_reg,    len_next;
    logic signed [8:0]   loops_reg,  loops_next;
    logic [31:0]         now_reg,    now_next;
    logic [15:0]         fill_reg,   fill_next;
    logic [CW-1:0]       sel_reg,    sel_next;
    logic [CW:0]         rp_reg,     rp_next;
    logic [CW-1:0]       s1_idx_reg, s1_idx_next;
    logic [CW-1:0]       best_reg,   best_next;
    logic [31:0]         best_t_reg, best_t_next;
    logic [CW:0]         nres_reg,   nres_next;
    logic [CW:0]         dp_reg,     dp_next;
    logic [3:0]          pend_ch_reg, pend_ch_next;
    logic [3:0]          m_ch_reg,   m_ch_next;
    logic                m_copy_reg, m_copy_next;
    logic [31:0]         m_addr_reg, m_addr_next;
    logic [15:0]         m_bytes_reg, m_bytes_next;
    logic [7:0]          m_gain_reg, m_gain_next;
    logic [4:0]          m_active_reg, m_active_next;
    logic                m_paused_reg, m_paused_next;
    logic                m_last_reg, m_last_next;

    // voice table RAM
    logic                vram_we, vram_re;
    logic [CW-1:0]       vram_waddr, vram_raddr;
    voice_entry_t        vram_wdata, vram_rdata;

    // copy command buffer RAM
    logic                rram_we, rram_re;
    logic [CW-1:0]       rram_waddr, rram_raddr;
    copy_cmd_t           rram_wdata, rram_rdata;

    adv_t                adv;

    // misc derived values
    kind_t               s_kind;
    logic [3:0]          s_chan;
    logic [CW+3:0]       s_chan_wide;
    logic [CW-1:0]       s_chan_idx;
    logic                s_chan_ok;
    logic [CW+3:0]       s1_wide;
    logic [CW+3:0]       sel_wide;
    logic [CNTW+4:0]     cnt_wide;
    logic [CW-1:0]       free_idx;
    logic                free_any;
    logic                rd_more;
    logic                walk_done;
    logic [CW:0]         dp_plus;
    logic [7:0]          gain_clamped;
    logic                out_free;

    svalloc_ram #(
        .WIDTH ($bits(voice_entry_t)),
        .DEPTH (VOICES)
    ) u_voice_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .re    (vram_re),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    svalloc_ram #(
        .WIDTH ($bits(copy_cmd_t)),
        .DEPTH (VOICES)
    ) u_copy_ram (
        .clk   (clk),
        .we    (rram_we),
        .waddr (rram_waddr),
        .wdata (rram_wdata),
        .re    (rram_re),
        .raddr (rram_raddr),
        .rdata (rram_rdata)
    );

    svalloc_advance u_advance (
        .entry      (vram_rdata),
        .fill_bytes (fill_reg),
        .adv        (adv)
    );

    // lowest idle channel
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_idx = CW'(i);
                free_any = 1'b1;
            end
        end
    end

    // width adaptation of channel numbers and count
    always_comb
    begin
        s_kind       = kind_t'(s_tuser);
        s_chan       = s_tdata[S_CHAN_LO +: 4];
        s_chan_wide  = {{CW{1'b0}}, s_chan};
        s_chan_idx   = s_chan_wide[CW-1:0];
        s_chan_ok    = (s_chan_wide < (CW+4)'(VOICES));
        s1_wide      = {4'd0, s1_idx_reg};
        sel_wide     = {4'd0, sel_reg};
        cnt_wide     = {5'd0, count_reg};
        rd_more      = (rp_reg != (CW+1)'(VOICES));
        walk_done    = !rd_more && !s1_v_reg;
        dp_plus      = dp_reg + (CW+1)'(1);
        gain_clamped = (gain_reg > GAIN_UNITY) ? GAIN_UNITY : gain_reg;
        out_free     = !m_valid_reg || m_tready;
    end

    // next-state logic
    always_comb
    begin
        state_next    = state_reg;
        gain_next     = gain_reg;
        active_next   = active_reg;
        count_next    = count_reg;
        s1_v_next     = s1_v_reg;
        rd_ok_next    = rd_ok_reg;
        m_valid_next  = m_valid_reg;
        base_next     = base_reg;
        len_next      = len_reg;
        loops_next    = loops_reg;
        now_next      = now_reg;
        fill_next     = fill_reg;
        sel_next      = sel_reg;
        rp_next       = rp_reg;
        s1_idx_next   = s1_idx_reg;
        best_next     = best_reg;
        best_t_next   = best_t_reg;
        nres_next     = nres_reg;
        dp_next       = dp_reg;
        pend_ch_next  = pend_ch_reg;
        m_ch_next     = m_ch_reg;
        m_copy_next   = m_copy_reg;
        m_addr_next   = m_addr_reg;
        m_bytes_next  = m_bytes_reg;
        m_gain_next   = m_gain_reg;
        m_active_next = m_active_reg;
        m_paused_next = m_paused_reg;
        m_last_next   = m_last_reg;

        vram_we    = 1'b0;
        vram_waddr = s1_idx_reg;
        vram_wdata = adv.entry;
        vram_re    = 1'b0;
        vram_raddr = rp_reg[CW-1:0];
        rram_we    = 1'b0;
        rram_waddr = nres_reg[CW-1:0];
        rram_wdata = '{chan: s1_wide[3:0], address: vram_rdata.position, bytes: adv.amt};
        rram_re    = 1'b0;
        rram_raddr = dp_reg[CW-1:0];

        // config writes land at any time
        if (cfg_valid)
        begin
            gain_next = cfg_data;
        end

        // output beat taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        // table walk read side, shared by scan and fill
        if (state_reg == ST_SCAN || state_reg == ST_FILL)
        begin
            if (rd_more)
            begin
                vram_re     = 1'b1;
                rp_next     = rp_reg + (CW+1)'(1);
                s1_v_next   = 1'b1;
                s1_idx_next = rp_reg[CW-1:0];
            end
            else
            begin
                s1_v_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    base_next  = s_tdata[S_BASE_LO +: 32];
                    len_next   = s_tdata[S_LEN_LO +: 24];
                    loops_next = s_tdata[S_LOOPS_LO +: 9];
                    now_next   = s_tdata[S_NOW_LO +: 32];
                    fill_next  = s_tdata[S_FILL_LO +: 16];
                    unique case (s_kind)
                        KIND_PLAY:
                        begin
                            if (free_any)
                            begin
                                sel_next   = free_idx;
                                state_next = ST_PLAY_WR;
                            end
                            else
                            begin
                                rp_next    = '0;
                                s1_v_next  = 1'b0;
                                state_next = ST_SCAN;
                            end
                        end
                        KIND_FILL:
                        begin
                            rp_next    = '0;
                            s1_v_next  = 1'b0;
                            nres_next  = '0;
                            state_next = ST_FILL;
                        end
                        KIND_STOP:
                        begin
                            if (s_chan_ok && active_reg[s_chan_idx])
                            begin
                                active_next[s_chan_idx] = 1'b0;
                                count_next = count_reg - CNTW'(1);
                            end
                            pend_ch_next = s_chan;
                            state_next   = ST_EMIT;
                        end
                        default:
                        begin
                            pend_ch_next = 4'd0;
                            state_next   = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_PLAY_WR:
            begin
                vram_we    = 1'b1;
                vram_waddr = sel_reg;
                vram_wdata = '{position: base_reg, remaining: len_reg, start: base_reg,
                               length: len_reg, started_at: now_reg, loops: loops_reg};
                if (!active_reg[sel_reg])
                begin
                    count_next = count_reg + CNTW'(1);
                end
                active_next[sel_reg] = 1'b1;
                pend_ch_next = sel_wide[3:0];
                state_next   = ST_EMIT;
            end

            ST_SCAN:
            begin
                // oldest start time, first index wins ties
                if (s1_v_reg)
                begin
                    if (s1_idx_reg == '0 || vram_rdata.started_at < best_t_reg)
                    begin
                        best_next   = s1_idx_reg;
                        best_t_next = vram_rdata.started_at;
                    end
                end
                if (walk_done)
                begin
                    sel_next   = best_reg;
                    state_next = ST_PLAY_WR;
                end
            end

            ST_FILL:
            begin
                // advance each active voice and buffer its copy command
                if (s1_v_reg && active_reg[s1_idx_reg])
                begin
                    vram_we   = 1'b1;
                    rram_we   = 1'b1;
                    nres_next = nres_reg + (CW+1)'(1);
                    if (adv.stop)
                    begin
                        active_next[s1_idx_reg] = 1'b0;
                        count_next = count_reg - CNTW'(1);
                    end
                end
                if (walk_done)
                begin
                    if (nres_reg == '0)
                    begin
                        pend_ch_next = 4'd0;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        dp_next    = '0;
                        rd_ok_next = 1'b0;
                        state_next = ST_DRAIN;
                    end
                end
            end

            ST_DRAIN:
            begin
                // read ahead one command, hand it out when the output is free
                if (!rd_ok_reg)
                begin
                    rram_re    = 1'b1;
                    rd_ok_next = 1'b1;
                end
                else if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_ch_next     = rram_rdata.chan;
                    m_copy_next   = 1'b1;
                    m_addr_next   = rram_rdata.address;
                    m_bytes_next  = rram_rdata.bytes;
                    m_gain_next   = gain_clamped;
                    m_active_next = cnt_wide[4:0];
                    m_paused_next = (count_reg == '0);
                    m_last_next   = (dp_plus == nres_reg);
                    dp_next       = dp_plus;
                    if (dp_plus == nres_reg)
                    begin
                        rd_ok_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rram_re    = 1'b1;
                        rram_raddr = dp_plus[CW-1:0];
                    end
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_ch_next     = pend_ch_reg;
                    m_copy_next   = 1'b0;
                    m_addr_next   = 32'd0;
                    m_bytes_next  = 16'd0;
                    m_gain_next   = 8'd0;
                    m_active_next = cnt_wide[4:0];
                    m_paused_next = (count_reg == '0);
                    m_last_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            gain_reg    <= GAIN_UNITY;
            active_reg  <= '0;
            count_reg   <= '0;
            s1_v_reg    <= 1'b0;
            rd_ok_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            gain_reg    <= gain_next;
            active_reg  <= active_next;
            count_reg   <= count_next;
            s1_v_reg    <= s1_v_next;
            rd_ok_reg   <= rd_ok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        len_reg      <= len_next;
        loops_reg    <= loops_next;
        now_reg      <= now_next;
        fill_reg     <= fill_next;
        sel_reg      <= sel_next;
        rp_reg       <= rp_next;
        s1_idx_reg   <= s1_idx_next;
        best_reg     <= best_next;
        best_t_reg   <= best_t_next;
        nres_reg     <= nres_next;
        dp_reg       <= dp_next;
        pend_ch_reg  <= pend_ch_next;
        m_ch_reg     <= m_ch_next;
        m_copy_reg   <= m_copy_next;
        m_addr_reg   <= m_addr_next;
        m_bytes_reg  <= m_bytes_next;
        m_gain_reg   <= m_gain_next;
        m_active_reg <= m_active_next;
        m_paused_reg <= m_paused_next;
        m_last_reg   <= m_last_next;
    end

    // ports
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        cfg_ready = 1'b1;
        m_tvalid  = m_valid_reg;
        m_tuser   = m_copy_reg;
        m_tlast   = m_last_reg;
        m_tdata   = '0;
        m_tdata[M_CHAN_LO +: 4]   = m_ch_reg;
        m_tdata[M_ADDR_LO +: 32]  = m_addr_reg;
        m_tdata[M_BYTES_LO +: 16] = m_bytes_reg;
        m_tdata[M_GAIN_LO +: 8]   = m_gain_reg;
        m_tdata[M_ACTIVE_LO +: 5] = m_active_reg;
        m_tdata[M_PAUSED_LO]      = m_paused_reg;
    end

endmodule

`default_nettype wire

@@ rtl/svalloc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module svalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/svalloc_advance.sv @@
// Advances one voice entry by one output buffer: copy size, new position,
// loop reload or stop. Depends on svalloc_pkg.
`default_nettype none

module svalloc_advance (
    input  wire svalloc_pkg::voice_entry_t entry,
    input  wire logic [15:0]               fill_bytes,
    output svalloc_pkg::adv_t              adv
);

    import svalloc_pkg::*;

    logic [15:0] amt;
    logic [31:0] pos_adv;
    logic [23:0] rem_adv;

    // copy size is min(remaining, fill)
    always_comb
    begin
        if (entry.remaining < {8'd0, fill_bytes})
        begin
            amt = entry.remaining[15:0];
        end
        else
        begin
            amt = fill_bytes;
        end
        pos_adv = entry.position + {16'd0, amt};
        rem_adv = entry.remaining - {8'd0, amt};
    end

    // end of sound: reload while loops remain (a negative count loops forever), else stop
    always_comb
    begin
        adv.amt             = amt;
        adv.stop            = 1'b0;
        adv.entry           = entry;
        adv.entry.position  = pos_adv;
        adv.entry.remaining = rem_adv;
        if (rem_adv == 24'd0)
        begin
            if (entry.loops != 9'sd0)
            begin
                adv.entry.position  = entry.start;
                adv.entry.remaining = entry.length;
                if (!entry.loops[8])
                begin
                    adv.entry.loops = entry.loops - 9'sd1;
                end
            end
            else
            begin
                adv.stop = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
